@@ rtl/neighborhood_crowding_growth_rate_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Crowding growth rate unit: assertion macros
// Clocked assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef NEIGHBORHOOD_CROWDING_GROWTH_RATE_UNIT_DEFINES_SVH
`define NEIGHBORHOOD_CROWDING_GROWTH_RATE_UNIT_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define NCGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check an implication on every rising edge outside reset.
`define NCGR_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/ncgr_pkg.sv @@
// ----------------------------------------------------------------------------
// Crowding growth rate package
// Widths, register indexes, cell types and sequencer states.
// ----------------------------------------------------------------------------
package ncgr_pkg;

  localparam int WINDOW_POSITIONS = 36;
  localparam int LABEL_BITS       = 20;
  localparam int CNT_W            = 6;
  localparam int KCNT_W           = 7;
  localparam int CFG_DATA_W       = 20;
  localparam int CFG_INDEX_W      = 3;
  localparam int RATE_W           = 24;
  localparam int OUT_RATE_W       = 32;
  localparam int DVD_W            = 49;

  localparam logic [CFG_INDEX_W-1:0] REG_GROUP_A  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GROUP_B  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_R_LIMIT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_K_LIMIT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BETA     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CAP_R    = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_CAP_K    = 3'd7;

  localparam logic [1:0] TYPE_R  = 2'd1;
  localparam logic [1:0] TYPE_K  = 2'd2;
  localparam logic [1:0] STAGE_K = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_MUL0,
    ST_CROWD,
    ST_MULLO,
    ST_MULHI,
    ST_DIV,
    ST_SUM,
    ST_FIN
  } state_t;

endpackage

@@ rtl/ncgr_item_if.sv @@
// ----------------------------------------------------------------------------
// Crowding growth rate input channel
// One neighborhood position per beat.
// ----------------------------------------------------------------------------
interface ncgr_item_if;
  logic               valid;
  logic               ready;
  logic [19:0]        density_code;
  logic [19:0]        occupant_label;
  logic [1:0]         position_stage;
  logic [1:0]         center_type;
  logic signed [23:0] inherent_rate;
  logic               last_position;

  modport source (output valid, density_code, occupant_label, position_stage,
                  center_type, inherent_rate, last_position, input ready);
  modport sink (input valid, density_code, occupant_label, position_stage,
                center_type, inherent_rate, last_position, output ready);
endinterface

@@ rtl/ncgr_result_if.sv @@
// ----------------------------------------------------------------------------
// Crowding growth rate result channel
// One result beat per neighborhood.
// ----------------------------------------------------------------------------
interface ncgr_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] adjusted_rate;
  logic [5:0]         r_neighbors;
  logic [6:0]         k_neighbors;
  logic [6:0]         total_neighbors;

  modport source (output valid, adjusted_rate, r_neighbors, k_neighbors,
                  total_neighbors, input ready);
  modport sink (input valid, adjusted_rate, r_neighbors, k_neighbors,
                total_neighbors, output ready);
endinterface

@@ rtl/neighborhood_crowding_growth_rate_unit.sv @@
// A position with an empty label skips the label scan, any other scans the stored labels of
// its set until a match or the fill count is reached; each label memory has one read port.
// A crowded last position then runs the crowding products (ST_MUL0 to ST_MULHI), the 49-bit
// bit-serial divider and saturation before the result load; an uncrowded one loads after ST_CROWD.
// A result waiting in the output register does not stall input until the next result is ready.
// Reset (rst, synchronous) clears counters, state and config; label memories are not cleared.
// ----------------------------------------------------------------------------
// Neighborhood crowding growth rate unit
// Counts distinct r and K labels and stage-K positions of a window and adjusts the growth rate.
// ----------------------------------------------------------------------------
`include "neighborhood_crowding_growth_rate_unit_defines.svh"

module neighborhood_crowding_growth_rate_unit
  import ncgr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ncgr_item_if.sink              item,
  ncgr_result_if.source          result
);

  // configuration
  logic [19:0] group_a;
  logic [19:0] group_b;
  logic [14:0] r_limit;
  logic [14:0] k_limit;
  logic [15:0] alpha;
  logic [15:0] beta;
  logic [15:0] cap_r;
  logic [15:0] cap_k;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_a <= '0;
      group_b <= '0;
      r_limit <= '0;
      k_limit <= '0;
      alpha   <= '0;
      beta    <= '0;
      cap_r   <= 16'd256;
      cap_k   <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GROUP_A: group_a <= cfg_data[19:0];
        REG_GROUP_B: group_b <= cfg_data[19:0];
        REG_R_LIMIT: r_limit <= cfg_data[14:0];
        REG_K_LIMIT: k_limit <= cfg_data[14:0];
        REG_ALPHA:   alpha   <= cfg_data[15:0];
        REG_BETA:    beta    <= cfg_data[15:0];
        REG_CAP_R:   cap_r   <= cfg_data[15:0];
        REG_CAP_K:   cap_k   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  state_t state;
  state_t state_next;

  // item latch
  logic [LABEL_BITS-1:0] lab;
  logic                  sel_r;
  logic [1:0]            stage;
  logic [1:0]            ctype;
  logic signed [23:0]    rate;
  logic                  last;

  // label memories
  logic [LABEL_BITS-1:0] r_mem [WINDOW_POSITIONS];
  logic [LABEL_BITS-1:0] k_mem [WINDOW_POSITIONS];
  logic [LABEL_BITS-1:0] r_rdata;
  logic [LABEL_BITS-1:0] k_rdata;
  logic [CNT_W-1:0]      r_cnt;
  logic [CNT_W-1:0]      k_cnt;
  logic [CNT_W-1:0]      s2_cnt;
  logic [CNT_W-1:0]      idx;
  logic                  rd_pend;
  logic                  found;

  // rate datapath
  logic [CNT_W-1:0]   rc;
  logic [KCNT_W-1:0]  kc;
  logic               crowded;
  logic [22:0]        prod;
  logic [14:0]        lim;
  logic [15:0]        cap;
  logic [31:0]        crowd;
  logic [55:0]        mag;
  logic [DVD_W-1:0]   dvd;
  logic [15:0]        rem;
  logic [5:0]         div_cnt;
  logic signed [31:0] res;

  // output register
  logic               out_valid;
  logic signed [31:0] out_rate;
  logic [5:0]         out_r;
  logic [6:0]         out_k;
  logic [6:0]         out_n;

  // combinational helpers
  logic                  in_range_r;
  logic [20:0]           b_top;
  logic [CNT_W-1:0]      sel_cnt;
  logic [LABEL_BITS-1:0] rdata;
  logic                  hit;
  logic                  found_any;
  logic                  issue;
  logic                  scan_done;
  logic                  add_new;
  logic [CNT_W-1:0]      r_upd;
  logic [CNT_W-1:0]      k_upd;
  logic [CNT_W-1:0]      s2_upd;
  logic [KCNT_W-1:0]     n;
  logic [23:0]           arate;
  logic [39:0]           hi_prod;
  logic [55:0]           mag_sum;
  logic [16:0]           rem_sh;
  logic                  rem_ge;
  logic signed [50:0]    wide;
  logic                  load_out;

  assign b_top = {1'b0, group_a} + {2'b0, group_b[19:1]};
  assign in_range_r =
      (item.density_code != '0 && item.density_code <= {1'b0, group_a[19:1]}) ||
      (item.density_code > group_a && {1'b0, item.density_code} <= b_top);

  assign sel_cnt   = sel_r ? r_cnt : k_cnt;
  assign rdata     = sel_r ? r_rdata : k_rdata;
  assign hit       = rd_pend && rdata == lab;
  assign found_any = found || hit;
  assign issue     = state == ST_SCAN && !found_any && idx < sel_cnt;
  assign scan_done = found_any || (idx == sel_cnt && !rd_pend);

  assign add_new = lab != '0 && !found && sel_cnt < CNT_W'(WINDOW_POSITIONS);
  assign r_upd   = r_cnt + CNT_W'(add_new && sel_r);
  assign k_upd   = k_cnt + CNT_W'(add_new && !sel_r);
  assign s2_upd  = s2_cnt +
                   CNT_W'(stage == STAGE_K && s2_cnt < CNT_W'(WINDOW_POSITIONS));

  assign n       = {1'b0, rc} + kc;
  assign arate   = rate[23] ? 24'(-rate) : 24'(rate);
  assign hi_prod = {16'b0, arate} * {24'b0, crowd[31:16]};
  assign mag_sum = mag + {hi_prod, 16'b0};
  assign rem_sh  = {rem, dvd[DVD_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, cap};
  assign wide    = rate[23] ? (51'(rate) + {2'b0, dvd}) : (51'(rate) - {2'b0, dvd});
  assign load_out = state == ST_FIN && (!out_valid || result.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item.valid) state_next = (item.occupant_label != '0) ? ST_SCAN : ST_UPD;
      end
      ST_SCAN:  if (scan_done) state_next = ST_UPD;
      ST_UPD:   state_next = last ? ST_MUL0 : ST_IDLE;
      ST_MUL0:  state_next = ST_CROWD;
      ST_CROWD: state_next = crowded ? ST_MULLO : ST_FIN;
      ST_MULLO: state_next = ST_MULHI;
      ST_MULHI: state_next = ST_DIV;
      ST_DIV:   if (div_cnt == 6'(DVD_W - 1)) state_next = ST_SUM;
      ST_SUM:   state_next = ST_FIN;
      ST_FIN:   if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign item.ready = state == ST_IDLE;

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    r_rdata <= r_mem[idx];
    k_rdata <= k_mem[idx];
    if (state == ST_UPD && add_new) begin
      if (sel_r) r_mem[r_cnt] <= lab;
      else       k_mem[k_cnt] <= lab;
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      r_cnt  <= '0;
      k_cnt  <= '0;
      s2_cnt <= '0;
    end else if (state == ST_UPD) begin
      if (last) begin
        r_cnt  <= '0;
        k_cnt  <= '0;
        s2_cnt <= '0;
      end else begin
        r_cnt  <= r_upd;
        k_cnt  <= k_upd;
        s2_cnt <= s2_upd;
      end
    end
  end

  // item latch and scan
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      found   <= 1'b0;
      idx     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          rd_pend <= 1'b0;
          found   <= 1'b0;
          idx     <= '0;
          if (item.valid) begin
            lab   <= item.occupant_label;
            sel_r <= in_range_r;
            stage <= item.position_stage;
            ctype <= item.center_type;
            rate  <= item.inherent_rate;
            last  <= item.last_position;
          end
        end
        ST_SCAN: begin
          rd_pend <= issue;
          found   <= found_any;
          if (issue) idx <= idx + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // rate datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_UPD: begin
        rc <= r_upd;
        kc <= {1'b0, k_upd} + {1'b0, s2_upd};
      end
      ST_MUL0: begin
        if (ctype == TYPE_R) begin
          crowded <= {n, 8'b0} >= r_limit;
          prod    <= {7'b0, alpha} * {16'b0, kc};
          lim     <= r_limit;
          cap     <= (cap_r == '0) ? 16'd1 : cap_r;
        end else begin
          crowded <= ctype == TYPE_K && {n, 8'b0} >= k_limit;
          prod    <= {7'b0, beta} * {17'b0, rc};
          lim     <= k_limit;
          cap     <= (cap_k == '0) ? 16'd1 : cap_k;
        end
      end
      ST_CROWD: begin
        crowd <= 32'({n, 16'b0}) + {1'b0, prod, 8'b0} - {9'b0, lim, 8'b0};
        res   <= 32'(rate);
      end
      ST_MULLO: mag <= 56'({16'b0, arate} * {24'b0, crowd[15:0]});
      ST_MULHI: begin
        // (|rate| * 2 * crowd) / 256, then divide by capacity
        dvd     <= mag_sum[55:7];
        rem     <= '0;
        div_cnt <= '0;
      end
      ST_DIV: begin
        rem     <= rem_ge ? 16'(rem_sh - {1'b0, cap}) : rem_sh[15:0];
        dvd     <= {dvd[DVD_W-2:0], rem_ge};
        div_cnt <= div_cnt + 1'b1;
      end
      ST_SUM: begin
        if (wide[50:31] != {20{wide[50]}})
          res <= wide[50] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
          res <= wide[31:0];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_rate <= res;
      out_r    <= rc;
      out_k    <= kc;
      out_n    <= n;
    end
  end

  assign result.valid           = out_valid;
  assign result.adjusted_rate   = out_rate;
  assign result.r_neighbors     = out_r;
  assign result.k_neighbors     = out_k;
  assign result.total_neighbors = out_n;

  `NCGR_ASSERT(a_r_cnt_bound, r_cnt <= CNT_W'(WINDOW_POSITIONS), "r label count past window")
  `NCGR_ASSERT(a_k_cnt_bound, k_cnt <= CNT_W'(WINDOW_POSITIONS), "K label count past window")
  `NCGR_ASSERT(a_scan_idx, idx <= sel_cnt || state != ST_SCAN, "scan index past fill count")
  `NCGR_ASSERT_IMP(a_load_clears, state == ST_UPD && last,
                   r_cnt == '0 && k_cnt == '0 && s2_cnt == '0, "counts kept after last")

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Crowding growth rate unit testbench
// Feeds neighborhood windows position by position under several register
// settings, predicts the distinct label counts and the crowding-adjusted
// rate of each window, and checks every result beat against that prediction
// while both channels stall in random bursts outside the final phase.
// ----------------------------------------------------------------------------
module tb;
  import ncgr_pkg::*;

  localparam int  PERIOD_HI   = 10;
  localparam int  PERIOD_LO   = 10;
  localparam int  DRAIN_WAIT  = 120;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  PHASES      = 6;
  localparam int  RAND_ITEMS  = 195;

  typedef struct {
    logic [19:0]        dens;
    logic [19:0]        occ;
    logic [1:0]         stage;
    logic [1:0]         ctype;
    logic signed [23:0] rate;
    logic               is_last;
  } position_t;

  typedef struct {
    logic signed [31:0] rate;
    logic [5:0]         r_cnt;
    logic [6:0]         k_cnt;
    logic [6:0]         tot_cnt;
  } growth_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  ncgr_item_if   item ();
  ncgr_result_if result ();

  neighborhood_crowding_growth_rate_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item.sink),
    .result    (result.source)
  );

  always begin
    #PERIOD_HI clk = 1'b1;
    #PERIOD_LO clk = 1'b0;
  end

  // register shadow
  logic [19:0] grp_a, grp_b;
  logic [14:0] r_limit, k_limit;
  logic [15:0] alpha_w, beta_w, cap_r, cap_k;

  // window state
  logic [19:0] r_labels[$];
  logic [19:0] k_labels[$];
  int          stage_two;

  position_t window_q[$];
  growth_t   growth_due[$];
  position_t cur;
  logic      beat_in = 1'b0;
  logic      calm = 1'b0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        errors = 0;
  int        results_seen = 0;
  int        items_sent = 0;
  longint    cycles = 0;

  initial begin
    item.valid          = 1'b0;
    item.density_code   = '0;
    item.occupant_label = '0;
    item.position_stage = '0;
    item.center_type    = '0;
    item.inherent_rate  = '0;
    item.last_position  = 1'b0;
    result.ready        = 1'b0;
    grp_a = '0; grp_b = '0; r_limit = '0; k_limit = '0;
    alpha_w = '0; beta_w = '0; cap_r = 16'd256; cap_k = 16'd256;
    stage_two = 0;
  end

  function automatic longint crowded(longint rate, longint crowd, logic [15:0] cap);
    longint dv;
    longint res;
    dv  = (cap == 0 ? 64'sd1 : longint'(cap)) * 256;
    res = rate - (rate * 2 * crowd) / dv;
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res;
  endfunction

  function automatic bit r_range(logic [19:0] d);
    longint a, b, v;
    a = longint'(grp_a);
    b = longint'(grp_b);
    v = longint'(d);
    return (v >= 1 && v <= a / 2) || (v > a && v <= a + b / 2);
  endfunction

  function automatic void store_label(ref logic [19:0] set[$], input logic [19:0] lab);
    if (lab == 0) return;
    foreach (set[i]) if (set[i] == lab) return;
    if (set.size() < WINDOW_POSITIONS) set.push_back(lab);
  endfunction

  // advance the window state by one position; close the window on last
  function automatic void absorb_position(position_t p);
    longint  rc, kc, n, res, crowd;
    growth_t g;
    if (r_range(p.dens)) store_label(r_labels, p.occ);
    else                 store_label(k_labels, p.occ);
    if (p.stage == STAGE_K && stage_two < WINDOW_POSITIONS) stage_two++;
    if (!p.is_last) return;
    rc  = longint'(r_labels.size());
    kc  = longint'(k_labels.size() + stage_two);
    n   = rc + kc;
    res = longint'(p.rate);
    if (p.ctype == TYPE_R && n * 256 >= longint'(r_limit)) begin
      crowd = n * 65536 + longint'(alpha_w) * kc * 256 - longint'(r_limit) * 256;
      res   = crowded(res, crowd, cap_r);
    end else if (p.ctype == TYPE_K && n * 256 >= longint'(k_limit)) begin
      crowd = longint'(beta_w) * rc * 256 + n * 65536 - longint'(k_limit) * 256;
      res   = crowded(res, crowd, cap_k);
    end
    g.rate    = res[31:0];
    g.r_cnt   = rc > 63 ? 6'd63 : rc[5:0];
    g.k_cnt   = kc > 127 ? 7'd127 : kc[6:0];
    g.tot_cnt = n > 127 ? 7'd127 : n[6:0];
    growth_due.push_back(g);
    r_labels.delete();
    k_labels.delete();
    stage_two = 0;
  endfunction

  // input side: sample the beat at the rising edge, drive at the falling one
  always @(posedge clk) begin
    beat_in = !rst && item.valid && item.ready;
    if (beat_in) begin
      absorb_position(cur);
      items_sent++;
    end
  end

  always @(negedge clk) begin
    logic nv;
    if (!rst && (!item.valid || beat_in)) begin
      nv = 1'b0;
      if (gap_left == 0 && !calm && $urandom_range(0, 12) == 0)
        gap_left = $urandom_range(1, 11);
      if (gap_left > 0) begin
        gap_left--;
      end else if (window_q.size() > 0) begin
        cur = window_q.pop_front();
        nv  = 1'b1;
        item.density_code   <= cur.dens;
        item.occupant_label <= cur.occ;
        item.position_stage <= cur.stage;
        item.center_type    <= cur.ctype;
        item.inherent_rate  <= cur.rate;
        item.last_position  <= cur.is_last;
      end
      item.valid <= nv;
    end
  end

  // output side
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (!calm && $urandom_range(0, 8) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      rdy = 1'b0;
    end
    result.ready <= rst ? 1'b0 : rdy;
  end

  always @(posedge clk) begin
    growth_t g;
    if (!rst && result.valid && result.ready) begin
      results_seen++;
      if (growth_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat, rate %0d", result.adjusted_rate);
      end else begin
        g = growth_due.pop_front();
        if (result.adjusted_rate !== g.rate || result.r_neighbors !== g.r_cnt ||
            result.k_neighbors !== g.k_cnt || result.total_neighbors !== g.tot_cnt) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected rate %0d r %0d k %0d n %0d, got rate %0d r %0d k %0d n %0d",
                     g.rate, g.r_cnt, g.k_cnt, g.tot_cnt, result.adjusted_rate,
                     result.r_neighbors, result.k_neighbors, result.total_neighbors);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_GROUP_A: grp_a   = val;
      REG_GROUP_B: grp_b   = val;
      REG_R_LIMIT: r_limit = val[14:0];
      REG_K_LIMIT: k_limit = val[14:0];
      REG_ALPHA:   alpha_w = val[15:0];
      REG_BETA:    beta_w  = val[15:0];
      REG_CAP_R:   cap_r   = val[15:0];
      REG_CAP_K:   cap_k   = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [19:0] a, logic [19:0] b, logic [14:0] rl, logic [14:0] kl,
                          logic [15:0] al, logic [15:0] be, logic [15:0] cr, logic [15:0] ck);
    write_reg(REG_GROUP_A, a);
    write_reg(REG_GROUP_B, b);
    write_reg(REG_R_LIMIT, 20'(rl));
    write_reg(REG_K_LIMIT, 20'(kl));
    write_reg(REG_ALPHA, 20'(al));
    write_reg(REG_BETA, 20'(be));
    write_reg(REG_CAP_R, 20'(cr));
    write_reg(REG_CAP_K, 20'(ck));
  endtask

  task automatic push_pos(logic [19:0] d, logic [19:0] o, logic [1:0] s, logic [1:0] t,
                          logic [23:0] r, logic l);
    position_t p;
    p.dens = d; p.occ = o; p.stage = s; p.ctype = t; p.rate = r; p.is_last = l;
    window_q.push_back(p);
  endtask

  function automatic logic [19:0] pick_density();
    longint a, b, v;
    a = longint'(grp_a);
    b = longint'(grp_b);
    case ($urandom_range(0, 5))
      0: v = longint'($urandom_range(0, 20'hFFFFF));
      1: v = longint'($urandom_range(1, 32'(a / 2 > 1 ? a / 2 : 1)));
      2: v = a + longint'($urandom_range(1, 32'(b / 2 > 1 ? b / 2 : 1)));
      3: v = 0;
      4: v = a;
      default: v = a + b / 2 + 1;
    endcase
    return v[19:0];
  endfunction

  function automatic logic [23:0] pick_rate();
    case ($urandom_range(0, 7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h010000;
      default: return 24'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  // random windows until the item budget of this phase is spent
  task automatic queue_windows(int budget);
    int len;
    bit pool;
    logic [1:0]  t;
    logic [23:0] r;
    logic [19:0] lab;
    while (budget > 0) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(37, 45) : $urandom_range(1, 36);
      pool = 1'($urandom_range(0, 1));
      t    = 2'($urandom_range(0, 3));
      r    = pick_rate();
      for (int i = 0; i < len; i++) begin
        lab = pool ? 20'($urandom_range(0, 6)) : 20'($urandom_range(0, 20'hFFFFF));
        if ($urandom_range(0, 15) == 0) begin
          t = 2'($urandom_range(0, 3));
          r = pick_rate();
        end
        push_pos(pick_density(), lab, 2'($urandom_range(0, 3)), t, r, i == len - 1);
      end
      budget -= len;
    end
  endtask

  task automatic drain();
    while (window_q.size() > 0 || item.valid || growth_due.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_regs(20'd8, 20'd8, 15'd0, 15'd0, 16'h0100, 16'h0080, 16'd256, 16'd512);
    // density codes 1..4 and 9..12 fall in the r range here
    push_pos(20'd1, 20'hFFFFF, 2'd2, TYPE_R, 24'h7FFFFF, 1'b1);
    push_pos(20'hFFFFF, 20'd0, 2'd3, TYPE_K, 24'h800000, 1'b1);
    push_pos(20'd0, 20'd5, 2'd0, 2'd0, 24'hFFFFFF, 1'b0);
    push_pos(20'd2, 20'd5, 2'd1, 2'd0, 24'hFFFFFF, 1'b0);
    push_pos(20'd9, 20'd5, 2'd2, 2'd0, 24'hFFFFFF, 1'b0);
    push_pos(20'd13, 20'd5, 2'd2, 2'd0, 24'hFFFFFF, 1'b1);
    push_pos(20'd3, 20'd7, 2'd0, 2'd3, 24'h123456, 1'b0);
    push_pos(20'd3, 20'd7, 2'd0, 2'd3, 24'h123456, 1'b1);
    for (int i = 0; i < 6; i++)
      push_pos(20'(i * 3), 20'(i + 1), 2'd2, TYPE_R, 24'h010000, i == 5);
    for (int i = 0; i < 6; i++)
      push_pos(20'(i * 2 + 1), 20'(20'hFFFF0 + i), 2'(i), TYPE_K, 24'hFF0000, i == 5);
    queue_windows(RAND_ITEMS - 20);
    drain();

    for (int ph = 1; ph < PHASES; ph++) begin
      case (ph)
        1: set_regs(20'hFFFFF, 20'hFFFFF, 15'h7FFF, 15'h7FFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF);
        2: set_regs(20'd0, 20'd0, 15'd0, 15'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        default:
          set_regs(20'($urandom_range(0, 64)), 20'($urandom_range(0, 64)),
                   15'($urandom_range(0, 36 * 256)), 15'($urandom_range(0, 15'h7FFF)),
                   16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                   16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'h0400)));
      endcase
      // no idling on the final phase
      if (ph == PHASES - 1) calm = 1'b1;
      queue_windows(RAND_ITEMS);
      drain();
    end

    $display("sent %0d positions over %0d register settings, checked %0d results",
             items_sent, PHASES, results_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
